/* src/cid_base32_sha256_extract_macros.svh */
// Assertion macros used by the extractor RTL core.
// Each macro assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef CID_BASE32_SHA256_EXTRACT_MACROS_SVH
`define CID_BASE32_SHA256_EXTRACT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define CBSE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cbse assertion failed");

// Implication whose consequent is checked in the following cycle
`define CBSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbse assertion failed");

`else

`define CBSE_ASSERT(label, prop)
`define CBSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/cbse_pkg.sv */
`timescale 1ns / 1ps

package cbse_pkg;

    // Expected string and payload sizes
    localparam logic [6:0] CID_CHARS     = 7'd59;
    localparam logic [5:0] CONTENT_BYTES = 6'd36;
    localparam logic [6:0] CHAR_COUNT_MAX = 7'h7F;
    localparam logic [5:0] BYTES_MAX      = 6'h3F;

    // Multihash header layout
    localparam logic [7:0] DIGEST_LEN     = 8'd32;
    localparam logic [5:0] POS_VERSION    = 6'd0;
    localparam logic [5:0] POS_CODEC      = 6'd1;
    localparam logic [5:0] POS_HASH_KIND  = 6'd2;
    localparam logic [5:0] POS_DIGEST_LEN = 6'd3;
    localparam logic [5:0] HEADER_LEN     = 6'd4;
    localparam logic [5:0] DIGEST_END     = HEADER_LEN + 6'(DIGEST_LEN);

    // Special characters
    localparam logic [7:0] CHAR_PREFIX = 8'h62;  // 'b'
    localparam logic [7:0] CHAR_PAD    = 8'h3D;  // '='
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [4:0] DIGIT_BASE   = 5'd26;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_VERSION   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CODEC     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HASH_KIND = 2'd2;

    localparam logic [7:0] RST_VERSION   = 8'd1;
    localparam logic [7:0] RST_CODEC     = 8'd85;
    localparam logic [7:0] RST_HASH_KIND = 8'd18;

    // One result word
    typedef struct packed {
        logic       byte_present;
        logic [7:0] hash_byte;
        logic [4:0] byte_index;
        logic       done_res;
        logic       cid_ok;
    } result_t;

    // Base32 symbol lookup: {valid, value}
    function automatic logic [5:0] sym_decode(input logic [7:0] c);
        logic [5:0] r;
        r = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = {1'b1, 5'(c - CHAR_UPPER_A)};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = {1'b1, 5'(c - CHAR_LOWER_A)};
        end
        else if (c >= CHAR_DIGIT_2 && c <= CHAR_DIGIT_7) begin
            r = {1'b1, 5'(c - CHAR_DIGIT_2) + DIGIT_BASE};
        end
        return r;
    endfunction

endpackage

/* src/cbse_core.sv */
`timescale 1ns / 1ps
`include "cid_base32_sha256_extract_macros.svh"

module cbse_core
#(
    parameter logic [6:0] CID_CHARS     = cbse_pkg::CID_CHARS,
    parameter logic [5:0] CONTENT_BYTES = cbse_pkg::CONTENT_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cbse_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [7:0]                       cfg_wdata,
    input  logic                             in_valid,
    input  logic [7:0]                       char_code,
    input  logic                             last_char,
    output logic                             push,
    output cbse_pkg::result_t                res
);

    logic [7:0]  version_reg;
    logic [7:0]  codec_reg;
    logic [7:0]  hash_kind_reg;

    logic [6:0]  count_reg, count_next;
    logic [11:0] store_reg, store_next;
    logic [3:0]  held_reg, held_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic        bad_reg, bad_next;
    logic        pad_reg, pad_next;

    logic        first;
    logic [5:0]  sym;
    logic [11:0] shifted;
    logic [3:0]  held_sum;
    logic [3:0]  held_left;
    logic [7:0]  dec_byte;
    logic        have_byte;
    logic [7:0]  hash_byte;
    logic [4:0]  byte_index;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= cbse_pkg::RST_VERSION;
            codec_reg     <= cbse_pkg::RST_CODEC;
            hash_kind_reg <= cbse_pkg::RST_HASH_KIND;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                cbse_pkg::REG_VERSION:   version_reg   <= cfg_wdata;
                cbse_pkg::REG_CODEC:     codec_reg     <= cfg_wdata;
                cbse_pkg::REG_HASH_KIND: hash_kind_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-character decode and header check
    always_comb
    begin
        first      = (count_reg == '0);
        count_next = (count_reg != cbse_pkg::CHAR_COUNT_MAX) ? count_reg + 7'd1 : count_reg;
        sym        = cbse_pkg::sym_decode(char_code);
        shifted    = {store_reg[6:0], sym[4:0]};
        held_sum   = held_reg + 4'd5;
        held_left  = held_sum - 4'd8;
        dec_byte   = 8'(shifted >> held_left);

        store_next = store_reg;
        held_next  = held_reg;
        bytes_next = bytes_reg;
        bad_next   = bad_reg;
        pad_next   = pad_reg;
        have_byte  = 1'b0;
        hash_byte  = '0;
        byte_index = '0;

        if (first)
        begin
            if (char_code != cbse_pkg::CHAR_PREFIX)
                bad_next = 1'b1;
        end
        else if (!bad_reg && !pad_reg)
        begin
            if (char_code == cbse_pkg::CHAR_PAD)
                pad_next = 1'b1;
            else if (!sym[5])
                bad_next = 1'b1;
            else
            begin
                store_next = shifted;
                held_next  = held_sum;
                if (held_sum >= 4'd8)
                begin
                    held_next = held_left;
                    if (bytes_reg != cbse_pkg::BYTES_MAX)
                        bytes_next = bytes_reg + 6'd1;
                    if (bytes_reg == cbse_pkg::POS_VERSION)
                    begin
                        if (dec_byte != version_reg)
                            bad_next = 1'b1;
                    end
                    else if (bytes_reg == cbse_pkg::POS_CODEC)
                    begin
                        if (dec_byte != codec_reg)
                            bad_next = 1'b1;
                    end
                    else if (bytes_reg == cbse_pkg::POS_HASH_KIND)
                    begin
                        if (dec_byte != hash_kind_reg)
                            bad_next = 1'b1;
                    end
                    else if (bytes_reg == cbse_pkg::POS_DIGEST_LEN)
                    begin
                        if (dec_byte != cbse_pkg::DIGEST_LEN)
                            bad_next = 1'b1;
                    end
                    else if (bytes_reg >= cbse_pkg::HEADER_LEN &&
                             bytes_reg < cbse_pkg::DIGEST_END)
                    begin
                        have_byte  = 1'b1;
                        hash_byte  = dec_byte;
                        byte_index = 5'(bytes_reg - cbse_pkg::HEADER_LEN);
                    end
                end
            end
        end

        res.byte_present = have_byte;
        res.hash_byte    = hash_byte;
        res.byte_index   = byte_index;
        res.done_res     = last_char;
        res.cid_ok       = last_char && (count_next == CID_CHARS) && !bad_next &&
                           (bytes_next == CONTENT_BYTES);
        push             = in_valid && (have_byte || last_char);
    end

    // String state; cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            store_reg <= '0;
            held_reg  <= '0;
            bytes_reg <= '0;
            bad_reg   <= 1'b0;
            pad_reg   <= 1'b0;
        end
        else if (in_valid)
        begin
            if (last_char)
            begin
                count_reg <= '0;
                store_reg <= '0;
                held_reg  <= '0;
                bytes_reg <= '0;
                bad_reg   <= 1'b0;
                pad_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                store_reg <= store_next;
                held_reg  <= held_next;
                bytes_reg <= bytes_next;
                bad_reg   <= bad_next;
                pad_reg   <= pad_next;
            end
        end
    end

    `CBSE_ASSERT(a_held_range, held_reg < 4'd8)
    `CBSE_ASSERT(a_byte_clean, !(push && res.byte_present) || (!bad_reg && !pad_reg))
    `CBSE_ASSERT(a_ok_on_done, !res.cid_ok || res.done_res)
    `CBSE_ASSERT_NEXT(a_clear_after_last, in_valid && last_char,
                      count_reg == '0 && bytes_reg == '0 && !bad_reg)

endmodule

/* src/cbse_out_reg.sv */
`timescale 1ns / 1ps

module cbse_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cbse_pkg::result_t res,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output cbse_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    cbse_pkg::result_t res_reg;

    // Room for a new word when empty or draining this cycle
    always_comb
    begin
        can_take = !valid_reg || out_ready;
        if (push)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload holds until replaced
    always_ff @(posedge clk)
    begin
        if (push)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* src/cid_base32_sha256_extract.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata[7:0] char_code, s_tlast last_char
// m_*       out        m_tvalid/m_tready  m_tdata hash_byte/byte_index/cid_ok,
//                                         m_tuser byte_present, m_tlast done_res
// cfg_*     in         cfg_we             cfg_addr register index, cfg_wdata value
//
// One character per cycle while s_tready is high; a word appears on m_* the cycle after its character.
// Decode, header check and result build are one combinational pass into the output register.
// Reset is asynchronous, active low, and takes effect at once (no clearing pass).
// s_tready is low only while the output register holds a word that m_tready does not take.

module cid_base32_sha256_extract
#(
    parameter logic [6:0] CID_CHARS     = cbse_pkg::CID_CHARS,
    parameter logic [5:0] CONTENT_BYTES = cbse_pkg::CONTENT_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cbse_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [7:0]                       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] char_code
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [7:0] hash_byte, [12:8] byte_index,
                                                        // [13] cid_ok, [15:14] zero
    output logic                             m_tuser,   // [0] byte_present
    output logic                             m_tlast
);

    logic              accept;
    logic              push;
    logic              can_take;
    cbse_pkg::result_t res;
    cbse_pkg::result_t out_res;

    assign s_tready = can_take;
    assign accept   = s_tvalid && can_take;

    cbse_core
    #(
        .CID_CHARS     (CID_CHARS),
        .CONTENT_BYTES (CONTENT_BYTES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (accept),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .push      (push),
        .res       (res)
    );

    cbse_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Output word packing
    assign m_tdata = {2'b00, out_res.cid_ok, out_res.byte_index, out_res.hash_byte};
    assign m_tuser = out_res.byte_present;
    assign m_tlast = out_res.done_res;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES  = 400;   // long receiver back-pressure stretch
    localparam int ENC_BITS     = 290;   // 58 symbols of 5 bits carry the 36 content bytes
    localparam int ENC_SYMS     = 58;

    typedef logic [7:0] char_q_t[$];

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cbse_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]                      cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;   // [7:0] char_code
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [15:0]                     m_tdata;   // [7:0] hash_byte, [12:8] byte_index, [13] cid_ok
    logic                            m_tuser;   // [0] byte_present
    logic                            m_tlast;

    bit calm;           // no idling on either side while set
    int hold_asks;      // bumped to request one receiver hold-off
    int chars_sent;
    int quiet;

    // Base32 symbol of a character, -1 outside the alphabet
    function automatic int symbol_of(logic [7:0] c);
        if (c >= cbse_pkg::CHAR_UPPER_A && c <= cbse_pkg::CHAR_UPPER_Z)
            return int'(c - cbse_pkg::CHAR_UPPER_A);
        if (c >= cbse_pkg::CHAR_LOWER_A && c <= cbse_pkg::CHAR_LOWER_Z)
            return int'(c - cbse_pkg::CHAR_LOWER_A);
        if (c >= cbse_pkg::CHAR_DIGIT_2 && c <= cbse_pkg::CHAR_DIGIT_7)
            return int'(c - cbse_pkg::CHAR_DIGIT_2) + int'(cbse_pkg::DIGIT_BASE);
        return -1;
    endfunction

    // Tracks the decode of the CID string and queues the words it must produce
    class digest_tracker;
        logic [7:0] want_version = cbse_pkg::RST_VERSION;
        logic [7:0] want_codec   = cbse_pkg::RST_CODEC;
        logic [7:0] want_hash    = cbse_pkg::RST_HASH_KIND;

        logic [6:0]  n_chars = '0;
        logic [11:0] bit_buf = '0;
        logic [3:0]  bits_in = '0;
        logic [5:0]  n_bytes = '0;
        bit          bad     = 1'b0;
        bit          padded  = 1'b0;

        cbse_pkg::result_t words_due[$];
        int                faults  = 0;

        function int pending();
            return words_due.size();
        endfunction

        function void take_char(logic [7:0] c, logic tail);
            bit                is_first;
            bit                got;
            logic [7:0]        b;
            logic [5:0]        pos;
            int                v;
            cbse_pkg::result_t w;
            is_first = (n_chars == 0);
            got = 1'b0;
            b = '0;
            pos = '0;
            if (n_chars != cbse_pkg::CHAR_COUNT_MAX)
                n_chars++;

            if (is_first)
            begin
                if (c != cbse_pkg::CHAR_PREFIX)
                    bad = 1'b1;
            end
            else if (!bad && !padded)
            begin
                v = symbol_of(c);
                if (c == cbse_pkg::CHAR_PAD)
                    padded = 1'b1;
                else if (v < 0)
                    bad = 1'b1;
                else
                begin
                    bit_buf = {bit_buf[6:0], 5'(v)};
                    bits_in += 4'd5;
                    if (bits_in >= 4'd8)
                    begin
                        bits_in -= 4'd8;
                        b = 8'(bit_buf >> bits_in);
                        pos = n_bytes;
                        if (n_bytes != cbse_pkg::BYTES_MAX)
                            n_bytes++;
                        // header bytes gate validity, digest bytes go out
                        if (pos == cbse_pkg::POS_VERSION && b != want_version)
                            bad = 1'b1;
                        else if (pos == cbse_pkg::POS_CODEC && b != want_codec)
                            bad = 1'b1;
                        else if (pos == cbse_pkg::POS_HASH_KIND && b != want_hash)
                            bad = 1'b1;
                        else if (pos == cbse_pkg::POS_DIGEST_LEN && b != cbse_pkg::DIGEST_LEN)
                            bad = 1'b1;
                        else if (pos >= cbse_pkg::HEADER_LEN && pos < cbse_pkg::DIGEST_END)
                            got = 1'b1;
                    end
                end
            end

            if (got || tail)
            begin
                w.byte_present = got;
                w.hash_byte    = got ? b : 8'h00;
                w.byte_index   = got ? 5'(pos - cbse_pkg::HEADER_LEN) : 5'd0;
                w.done_res     = tail;
                w.cid_ok       = tail && n_chars == cbse_pkg::CID_CHARS && !bad
                                 && n_bytes == cbse_pkg::CONTENT_BYTES;
                words_due = {words_due, w};
            end

            // string over: everything but the registers starts fresh
            if (tail)
            begin
                n_chars = '0;
                bit_buf = '0;
                bits_in = '0;
                n_bytes = '0;
                bad     = 1'b0;
                padded  = 1'b0;
            end
        endfunction

        function void check_field(string what, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                faults++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            end
        endfunction

        function void match_word(logic [15:0] data, logic user, logic tail);
            cbse_pkg::result_t w;
            if (words_due.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected word, expected none, actual data %h user %b last %b",
                         $time, data, user, tail);
                return;
            end
            w = words_due.pop_front();
            check_field("byte_present", 8'(w.byte_present), 8'(user));
            check_field("hash_byte", w.hash_byte, data[7:0]);
            check_field("byte_index", 8'(w.byte_index), 8'(data[12:8]));
            check_field("done_res", 8'(w.done_res), 8'(tail));
            check_field("cid_ok", 8'(w.cid_ok), 8'(data[13]));
            check_field("tdata pad", 8'h00, 8'(data[15:14]));
        endfunction
    endclass

    digest_tracker tracker;

    cid_base32_sha256_extract DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: check words, random back-pressure, long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.match_word(m_tdata, m_tuser, m_tlast);
            if (hold_asks != holds_served)
            begin
                holds_served = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    // One character, with an optional gap before it
    task automatic send_char(input logic [7:0] c, input logic tail);
        if (!calm && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= tail;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_char(c, tail);
    endtask

    task automatic send_chars(input char_q_t q);
        int last_i;
        last_i = q.size() - 1;
        chars_sent += q.size();
        for (int i = 0; i <= last_i; i++)
            send_char(q[i], i == last_i);
    endtask

    // Stop offering and wait for every outstanding word
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0] ver, input logic [7:0] codec,
                             input logic [7:0] hash);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= cbse_pkg::REG_VERSION;
        cfg_wdata <= ver;
        @(posedge clk);
        cfg_addr  <= cbse_pkg::REG_CODEC;
        cfg_wdata <= codec;
        @(posedge clk);
        cfg_addr  <= cbse_pkg::REG_HASH_KIND;
        cfg_wdata <= hash;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.want_version = ver;
        tracker.want_codec   = codec;
        tracker.want_hash    = hash;
    endtask

    function automatic logic [7:0] sym_char(logic [4:0] v);
        if (v < cbse_pkg::DIGIT_BASE)
            return ($urandom_range(1) ? cbse_pkg::CHAR_UPPER_A : cbse_pkg::CHAR_LOWER_A)
                   + 8'(v);
        return cbse_pkg::CHAR_DIGIT_2 + 8'(v - cbse_pkg::DIGIT_BASE);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (symbol_of(c) >= 0 || c == cbse_pkg::CHAR_PAD);
        return c;
    endfunction

    // One random CID string, mostly well formed, with the usual ways to break it
    task automatic run_random_cid();
        char_q_t         q;
        logic [7:0]      hdr[4];
        logic [7:0]      c;
        logic [ENC_BITS-1:0] stream;
        int              kind;
        int              p;
        int              n;
        kind = $urandom_range(99);
        hdr[0] = tracker.want_version;
        hdr[1] = tracker.want_codec;
        hdr[2] = tracker.want_hash;
        hdr[3] = cbse_pkg::DIGEST_LEN;
        if (kind >= 50 && kind < 58)
            hdr[$urandom_range(3)] ^= 8'($urandom_range(1, 255));

        // pack header and random digest, then encode 5 bits per symbol
        stream = '0;
        for (int k = 0; k < int'(cbse_pkg::CONTENT_BYTES); k++)
            stream[ENC_BITS-1-8*k -: 8] = (k < 4) ? hdr[k] : 8'($urandom_range(255));
        q = {q, cbse_pkg::CHAR_PREFIX};
        for (int i = 0; i < ENC_SYMS; i++)
            q = {q, sym_char(stream[ENC_BITS-1-5*i -: 5])};

        if (kind >= 58 && kind < 63)
        begin
            // wrong prefix
            do
                c = 8'($urandom_range(255));
            while (c == cbse_pkg::CHAR_PREFIX);
            q[0] = c;
        end
        else if (kind >= 63 && kind < 71)
            q[$urandom_range(1, ENC_SYMS)] = junk_char();
        else if (kind >= 71 && kind < 78)
        begin
            // early padding, junk after it is only counted
            p = $urandom_range(1, ENC_SYMS);
            q[p] = cbse_pkg::CHAR_PAD;
            for (int j = p + 1; j <= ENC_SYMS; j++)
                q[j] = 8'($urandom_range(255));
        end
        else if (kind >= 78 && kind < 85)
        begin
            // truncated string
            n = $urandom_range(1, ENC_SYMS);
            q = q[0:n-1];
        end
        else if (kind >= 85 && kind < 91)
        begin
            // over-long; long enough at times to saturate both counters
            n = $urandom_range(1, 80);
            repeat (n) q = {q, sym_char(5'($urandom_range(31)))};
        end
        else if (kind >= 91 && kind < 95)
            repeat ($urandom_range(1, 3)) q = {q, cbse_pkg::CHAR_PAD};
        else if (kind >= 95)
        begin
            q.delete();
            n = $urandom_range(1, 8);
            repeat (n) q = {q, 8'($urandom_range(255))};
            if ($urandom_range(1))
                q[0] = cbse_pkg::CHAR_PREFIX;
        end

        send_chars(q);
    endtask

    task automatic run_until(input int target);
        while (chars_sent < target)
            run_random_cid();
    endtask

    initial
    begin : stimulus
        tracker = new;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        calm = 1'b0;
        hold_asks = 0;
        chars_sent = 0;
        quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone prefix, lone bad characters at both code extremes
        send_chars({cbse_pkg::CHAR_PREFIX});
        send_chars({8'h00});
        send_chars({8'hFF});
        // wrong prefix: the rest is not decoded
        send_chars({cbse_pkg::CHAR_LOWER_A, cbse_pkg::CHAR_PREFIX, cbse_pkg::CHAR_UPPER_A});
        // padding, then junk that is only counted
        send_chars({cbse_pkg::CHAR_PREFIX, cbse_pkg::CHAR_PAD, 8'h00, 8'hFF});
        // high code outside the alphabet
        send_chars({cbse_pkg::CHAR_PREFIX, 8'h80});
        // version byte decodes to 6: header mismatch
        send_chars({cbse_pkg::CHAR_PREFIX, cbse_pkg::CHAR_UPPER_A, cbse_pkg::CHAR_UPPER_Z,
                    cbse_pkg::CHAR_DIGIT_2, cbse_pkg::CHAR_DIGIT_7});
        // good version byte, then '{' and '1' just outside the alphabet
        send_chars({cbse_pkg::CHAR_PREFIX, cbse_pkg::CHAR_LOWER_A,
                    cbse_pkg::CHAR_LOWER_A + 8'd4, 8'h7B, 8'h31});

        // reset register values, with one long receiver hold-off
        run_until(200);
        hold_asks++;
        run_until(400);

        // all-zero header, sender pauses for a full drain halfway
        load_regs(8'h00, 8'h00, 8'h00);
        run_until(600);
        drain();
        run_until(800);

        load_regs(8'hFF, 8'hFF, 8'hFF);
        run_until(1200);

        // random header, no idling anywhere
        load_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        calm = 1'b1;
        run_until(1600);
        calm = 1'b0;

        load_regs(cbse_pkg::RST_VERSION, cbse_pkg::RST_CODEC, cbse_pkg::RST_HASH_KIND);
        run_until(1950);

        drain();
        repeat (8) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
